[rtl/core/key_press_long_press_repeater_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the key repeater RTL
// ---------------------------------------------------------------------------
`ifndef KEY_PRESS_LONG_PRESS_REPEATER_ASSERT_SVH
`define KEY_PRESS_LONG_PRESS_REPEATER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define KREP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("krep assertion failed");

// next-cycle implication, checked out of reset
`define KREP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("krep assertion failed");

`endif

[rtl/core/krep_pkg.sv]
// ---------------------------------------------------------------------------
// krep_pkg
// Shared types, constants and helpers of the key auto-repeat block.
// ---------------------------------------------------------------------------
package krep_pkg;

  localparam int NUM_KEYS  = 7;
  localparam int KEY_W     = 4;
  localparam int KEY_IDX_W = 3;
  localparam int TIME_W    = 32;
  localparam int CFG_W     = 16;
  localparam int FUNC_W    = 2;
  localparam int CFG_IDX_W = 2;

  // event kinds; code 3 behaves as an other event
  localparam logic [FUNC_W-1:0] FUNC_DOWN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UP    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_OTHER = 2'd2;

  localparam logic [KEY_W-1:0] KEY_ESCAPE = 4'd7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_REPORT_EN = 2'd3;

  localparam logic [15:0] LONG_PRESS_RST = 16'd500;
  localparam logic [15:0] REPEAT_RST     = 16'd100;

  typedef struct packed {
    logic [15:0]         long_press_ms;
    logic [15:0]         repeat_interval_ms;
    logic [NUM_KEYS-1:0] long_press_mask;
    logic                press_report_enable;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 quit;
    logic                 press;
    logic [KEY_IDX_W-1:0] press_key;
    logic [NUM_KEYS-1:0]  rep_mask;
    logic [NUM_KEYS-1:0]  held;
  } job_t;

  function automatic logic [KEY_IDX_W-1:0] lowest_idx(input logic [NUM_KEYS-1:0] mask);
    logic [KEY_IDX_W-1:0] idx;
    idx = '0;
    for (int i = NUM_KEYS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = KEY_IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/core/krep_front.sv]
// ---------------------------------------------------------------------------
// krep_front
// Accepts key events, tracks held keys and press times, classifies each
// word into a job for the back end.
// ---------------------------------------------------------------------------
`include "key_press_long_press_repeater_assert.svh"

module krep_front import krep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [TIME_W-1:0]    in_now_ms,
  input  logic                 q_full,
  output logic                 q_push,
  output job_t                 q_data
);

  logic [NUM_KEYS-1:0]  held_r, held_nxt;
  logic [TIME_W-1:0]    press_time_r [NUM_KEYS];
  logic [TIME_W-1:0]    last_check_r;
  logic                 esc_up, tracked, rise, check;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [TIME_W-1:0]    since_check;
  logic [TIME_W-1:0]    eff_time [NUM_KEYS];
  logic [NUM_KEYS-1:0]  long_vec;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    esc_up      = (in_func == FUNC_UP) && (in_key == KEY_ESCAPE);
    tracked     = in_key < KEY_W'(NUM_KEYS);
    key_idx     = in_key[KEY_IDX_W-1:0];
    rise        = tracked && (in_func == FUNC_DOWN) && !held_r[key_idx];
    held_nxt    = held_r;
    if (rise) begin
      held_nxt[key_idx] = 1'b1;
    end else if (tracked && (in_func == FUNC_UP)) begin
      held_nxt[key_idx] = 1'b0;
    end
    since_check = in_now_ms - last_check_r;
    check       = since_check >= TIME_W'(cfg.repeat_interval_ms);
    for (int i = 0; i < NUM_KEYS; i++) begin
      eff_time[i] = (rise && (key_idx == KEY_IDX_W'(i))) ? in_now_ms : press_time_r[i];
      long_vec[i] = (in_now_ms - eff_time[i]) >= TIME_W'(cfg.long_press_ms);
    end

    q_data = '0;
    if (esc_up) begin
      q_data.quit = 1'b1;
      q_data.held = held_r;
    end else begin
      q_data.press     = rise && cfg.press_report_enable;
      q_data.press_key = key_idx;
      q_data.rep_mask  = (check && cfg.press_report_enable) ?
                         (cfg.long_press_mask & held_nxt & long_vec) : '0;
      q_data.held      = held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      last_check_r <= '0;
    end else if (q_push && !esc_up) begin
      held_r <= held_nxt;
      if (check) begin
        last_check_r <= in_now_ms;
      end
    end
  end

  // a held key always has a written press time, so no reset here
  always_ff @(posedge clk) begin
    if (q_push && !esc_up && rise) begin
      press_time_r[key_idx] <= in_now_ms;
    end
  end

  `KREP_ASSERT_NXT(a_esc_keeps_held, q_push && esc_up, $stable(held_r))
  `KREP_ASSERT_NXT(a_press_sets_held, q_push && q_data.press, held_r[$past(key_idx)])

endmodule

[rtl/core/krep_fifo.sv]
// ---------------------------------------------------------------------------
// krep_fifo
// Short job queue between the front and back ends.
// ---------------------------------------------------------------------------
`include "key_press_long_press_repeater_assert.svh"

module krep_fifo import krep_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_data,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output job_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = count_r == CNT_W'(DEPTH);
  assign not_empty = count_r != '0;
  assign rd_data   = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `KREP_ASSERT_NXT(a_fill_tracks, push && !pop, count_r == $past(count_r) + 1'b1)

endmodule

[rtl/core/krep_back.sv]
// ---------------------------------------------------------------------------
// krep_back
// Expands one job into its result words, one word per cycle while the
// receiver is ready, through an output register.
// ---------------------------------------------------------------------------
`include "key_press_long_press_repeater_assert.svh"

module krep_back import krep_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  job_t                 q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_press_valid,
  output logic [KEY_IDX_W-1:0] out_press_key,
  output logic                 out_quit,
  output logic [NUM_KEYS-1:0]  out_held_keys,
  output logic                 out_last
);

  logic                 busy_r, busy_nxt;
  logic                 pend_press_r, pend_press_nxt;
  logic [NUM_KEYS-1:0]  pend_mask_r, pend_mask_nxt;
  logic                 pend_stat_r, pend_stat_nxt;
  logic [KEY_IDX_W-1:0] key_r;
  logic [NUM_KEYS-1:0]  held_r;
  logic                 quit_r;

  logic                 out_valid_r, out_pv_r, out_quit_r, out_last_r;
  logic [KEY_IDX_W-1:0] out_key_r;
  logic [NUM_KEYS-1:0]  out_held_r;

  logic                 emit, done, res_pv, res_last;
  logic [KEY_IDX_W-1:0] res_key;
  logic [NUM_KEYS-1:0]  mask_rest;

  always_comb begin
    emit           = busy_r && (!out_valid_r || out_ready);
    mask_rest      = pend_mask_r & (pend_mask_r - 1'b1);
    pend_press_nxt = pend_press_r;
    pend_mask_nxt  = pend_mask_r;
    pend_stat_nxt  = pend_stat_r;
    res_pv         = 1'b0;
    res_key        = '0;
    res_last       = 1'b1;
    // press report first, then repeats in key order, else one status word
    if (pend_press_r) begin
      res_pv         = 1'b1;
      res_key        = key_r;
      res_last       = pend_mask_r == '0;
      pend_press_nxt = 1'b0;
    end else if (pend_mask_r != '0) begin
      res_pv        = 1'b1;
      res_key       = lowest_idx(pend_mask_r);
      res_last      = mask_rest == '0;
      pend_mask_nxt = mask_rest;
    end else begin
      pend_stat_nxt = 1'b0;
    end
    done     = emit && res_last;
    q_pop    = q_not_empty && (!busy_r || done);
    busy_nxt = q_pop ? 1'b1 : (done ? 1'b0 : busy_r);
    if (q_pop) begin
      pend_press_nxt = q_data.press;
      pend_mask_nxt  = q_data.rep_mask;
      pend_stat_nxt  = !q_data.press && (q_data.rep_mask == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pend_press_r <= 1'b0;
      pend_mask_r  <= '0;
      pend_stat_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit || q_pop) begin
        pend_press_r <= pend_press_nxt;
        pend_mask_r  <= pend_mask_nxt;
        pend_stat_r  <= pend_stat_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      key_r  <= q_data.press_key;
      held_r <= q_data.held;
      quit_r <= q_data.quit;
    end
    if (emit) begin
      out_pv_r   <= res_pv;
      out_key_r  <= res_key;
      out_quit_r <= quit_r;
      out_held_r <= held_r;
      out_last_r <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_press_valid = out_pv_r;
  assign out_press_key   = out_key_r;
  assign out_quit        = out_quit_r;
  assign out_held_keys   = out_held_r;
  assign out_last        = out_last_r;

  `KREP_ASSERT_IMP(a_busy_has_work, busy_r, pend_press_r || (pend_mask_r != '0) || pend_stat_r)
  `KREP_ASSERT_IMP(a_quit_alone, out_valid_r && out_quit_r, !out_pv_r && out_last_r)

endmodule

[rtl/core/key_press_long_press_repeater.sv]
// ---------------------------------------------------------------------------
// key_press_long_press_repeater
// Seven-key press tracker with long-press auto-repeat reports.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one key event word: event kind,
//   key index and the current millisecond time. Result channel
//   (out_valid/out_ready) returns one to eight words per event: a press
//   report first, then repeat reports in key order, or a single status word.
//   out_last marks the final word of an event; out_held_keys shows the held
//   keys after that event. Releasing escape yields one word with out_quit set.
//   The first word of an event passes through the job queue, the back end's
//   pending registers and the output register. The back end then sends one
//   word per cycle while the receiver is ready, and the next event's job
//   loads in the same cycle the last word goes out.
//   The front end takes a new event every cycle while the job queue
//   (FIFO_DEPTH entries) has room; a stalled receiver holds the output
//   register, then the back end, then fills the queue and drops in_ready.
//   Reset (synchronous, rst_n low) clears held keys, the last check time,
//   the queue and the output register, and loads register defaults:
//   long press 500 ms, repeat interval 100 ms, mask 0, reports off.
//   Configuration writes (cfg_we) take effect at the next edge.
// ---------------------------------------------------------------------------
module key_press_long_press_repeater import krep_pkg::*; #(
  parameter int FIFO_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FUNC_W-1:0]    in_func,
  input  logic [KEY_W-1:0]     in_key,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_press_valid,
  output logic [KEY_IDX_W-1:0] out_press_key,
  output logic                 out_quit,
  output logic [NUM_KEYS-1:0]  out_held_keys,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_not_empty;
  job_t q_wr_data, q_rd_data;

  // register file: write only; write it only while the block is idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ms       <= LONG_PRESS_RST;
      cfg_r.repeat_interval_ms  <= REPEAT_RST;
      cfg_r.long_press_mask     <= '0;
      cfg_r.press_report_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LONG_PRESS_MS:   cfg_r.long_press_ms       <= cfg_wdata;
        CFG_REPEAT_INTERVAL: cfg_r.repeat_interval_ms  <= cfg_wdata;
        CFG_LONG_PRESS_MASK: cfg_r.long_press_mask     <= cfg_wdata[NUM_KEYS-1:0];
        CFG_PRESS_REPORT_EN: cfg_r.press_report_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // front: classify each event word and update key state
  krep_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_key    (in_key),
    .in_now_ms (in_now_ms),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wr_data)
  );

  // job queue decouples classification from result emission
  krep_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_rd_data)
  );

  // back: emit result words one per cycle while the receiver is ready
  krep_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_data          (q_rd_data),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_press_valid (out_press_valid),
    .out_press_key   (out_press_key),
    .out_quit        (out_quit),
    .out_held_keys   (out_held_keys),
    .out_last        (out_last)
  );

endmodule
